/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the range list bitmap RTL.
// Each macro expects clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/rlb_pkg.sv */
// Package for the range list bitmap block: sizes, codes, types, helpers.
// No dependencies.
`timescale 1ns / 1ps

package rlb_pkg;

    localparam int SET_BITS   = 256;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = (SET_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int NUM_W      = $clog2(SET_BITS + 1);
    localparam int ACC_W      = NUM_W + 4;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int QDEPTH     = 2;

    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;

    localparam logic [0:0] REG_MAX_VALUE = 1'b0;
    localparam logic       MODE_CHAR     = 1'b0;
    localparam logic       KIND_STATUS   = 1'b0;
    localparam logic       KIND_QUERY    = 1'b1;

    typedef enum logic [2:0] {
        CL_DIGIT,
        CL_DASH,
        CL_DOT,
        CL_PLUS,
        CL_BLANK,
        CL_OTHER
    } char_class_t;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_SIGN   = 3'd1,
        ERR_FORMAT = 3'd2,
        ERR_NOMAX  = 3'd3,
        ERR_CAP    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_DASH,
        PH_SECOND
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_FINISH,
        S_REPLY
    } back_state_t;

    typedef struct packed {
        logic        mode;
        char_class_t cls;
        logic [3:0]  digit;
        logic        last;
        logic [7:0]  query;
    } entry_t;

    function automatic logic [NUM_W-1:0] acc_digit(input logic [NUM_W-1:0] n,
                                                   input logic [3:0] d);
        logic [ACC_W-1:0] v;
        v = ACC_W'(n) * ACC_W'(10) + ACC_W'(d);
        return (v > ACC_W'(SET_BITS)) ? NUM_W'(SET_BITS) : v[NUM_W-1:0];
    endfunction

endpackage

/* rtl/core/rlb_front.sv */
// Front end: classifies each incoming beat into a queue entry.
// Depends on rlb_pkg.
`timescale 1ns / 1ps

module rlb_front (
    input  logic           mode,
    input  logic [7:0]     char_code,
    input  logic           last_char,
    input  logic [7:0]     query_value,
    output rlb_pkg::entry_t entry
);
    import rlb_pkg::*;

    char_class_t cls;
    logic [7:0]  dval;

    assign dval = char_code - CH_ZERO;

    always_comb
    begin
        if (char_code >= CH_ZERO && char_code <= CH_NINE)
            cls = CL_DIGIT;
        else if (char_code == CH_DASH)
            cls = CL_DASH;
        else if (char_code == CH_DOT)
            cls = CL_DOT;
        else if (char_code == CH_PLUS)
            cls = CL_PLUS;
        else if (char_code == CH_SPACE || char_code == CH_TAB ||
                 char_code == CH_LF || char_code == CH_CR)
            cls = CL_BLANK;
        else
            cls = CL_OTHER;
    end

    always_comb
    begin
        entry.mode  = mode;
        entry.cls   = cls;
        entry.digit = dval[3:0];
        entry.last  = last_char;
        entry.query = query_value;
    end

endmodule

/* rtl/core/rlb_queue.sv */
// Two-entry queue between front and back ends.
// Depends on rlb_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module rlb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rlb_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output rlb_pkg::entry_t head,
    output logic            head_valid
);
    import rlb_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    entry_t             entries_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

`include "assert_macros.svh"
    `ASSERT_IMPLY(a_no_pop_empty, pop, count_reg != '0)
    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(QDEPTH))

endmodule

/* rtl/core/rlb_back.sv */
// Back end: list parser, word-serial range fill, bitmap and result register.
// Depends on rlb_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module rlb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  rlb_pkg::entry_t head,
    input  logic            head_valid,
    output logic            pop,
    input  logic [7:0]      max_value,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_kind,
    output logic [2:0]      out_status,
    output logic            out_member,
    output logic            out_empty
);
    import rlb_pkg::*;

    back_state_t          state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [NUM_W-1:0]     first_reg, first_next;
    logic [NUM_W-1:0]     second_reg, second_next;
    status_t              err_reg, err_next;
    logic                 open_reg, open_next;
    logic [WORD_BITS-1:0] bitmap_reg [WORD_COUNT];
    logic [WORD_BITS-1:0] bitmap_next [WORD_COUNT];
    logic [WIDX_W-1:0]    fill_w_reg, fill_w_next;
    logic [NUM_W-1:0]     fill_lo_reg, fill_lo_next;
    logic [NUM_W-1:0]     fill_top_reg, fill_top_next;
    logic                 pend_fin_reg, pend_fin_next;
    logic                 pend_reply_reg, pend_reply_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg, out_kind_next;
    status_t              out_status_reg, out_status_next;
    logic                 out_member_reg, out_member_next;
    logic                 out_empty_reg, out_empty_next;

    logic                 slot_free;
    logic                 take_char;
    logic                 take_query;
    logic                 empty;
    logic                 member;
    logic [NUM_W-1:0]     qv;

    phase_t               ph_e;
    logic [NUM_W-1:0]     first_e, second_e;
    status_t              err_e;
    phase_t               ph_c;
    logic [NUM_W-1:0]     first_c, second_c;
    status_t              err_c;
    logic                 rng_c, reproc, cap_c;
    logic [NUM_W-1:0]     lo_c, hi_c;

    logic                 rng_f, cap_f;
    status_t              err_f;
    logic [NUM_W-1:0]     hi_f;

    logic                 rng_req;
    logic [NUM_W-1:0]     rng_lo, rng_hi, rng_top;
    logic                 rng_fill;

    logic [WIDX_W-1:0]    lo_w, top_w;
    logic [WORD_BITS-1:0] fill_mask;
    logic                 fill_done;

    assign slot_free  = !out_valid_reg || out_ready;
    assign take_char  = (state_reg == S_IDLE) && head_valid && (head.mode == MODE_CHAR);
    assign take_query = (state_reg == S_IDLE) && head_valid && (head.mode != MODE_CHAR)
                        && slot_free;
    assign pop        = take_char || take_query;

    always_comb
    begin
        empty = 1'b1;
        for (int i = 0; i < WORD_COUNT; i++)
            if (bitmap_reg[i] != '0)
                empty = 1'b0;
    end

    assign qv = NUM_W'(head.query);

    always_comb
    begin
        member = 1'b0;
        if (qv < NUM_W'(SET_BITS))
            member = bitmap_reg[WIDX_W'(qv >> BIT_W)][qv[BIT_W-1:0]];
    end

    // character step, with list start folded in
    always_comb
    begin
        ph_e     = open_reg ? phase_reg : PH_IDLE;
        first_e  = open_reg ? first_reg : '0;
        second_e = open_reg ? second_reg : '0;
        err_e    = open_reg ? err_reg : ERR_NONE;
        ph_c     = ph_e;
        first_c  = first_e;
        second_c = second_e;
        err_c    = err_e;
        rng_c    = 1'b0;
        cap_c    = 1'b0;
        lo_c     = first_e;
        hi_c     = first_e;
        reproc   = 1'b0;
        if (err_e == ERR_NONE)
        begin
            unique case (ph_e)
                PH_FIRST:
                begin
                    if (head.cls == CL_DIGIT)
                        first_c = acc_digit(first_e, head.digit);
                    else if (head.cls == CL_DASH)
                    begin
                        second_c = '0;
                        ph_c     = PH_DASH;
                    end
                    else if (head.cls == CL_PLUS)
                    begin
                        ph_c = PH_IDLE;
                        if (max_value == '0)
                            err_c = ERR_NOMAX;
                        else
                        begin
                            rng_c = 1'b1;
                            hi_c  = NUM_W'(max_value);
                        end
                    end
                    else
                    begin
                        rng_c  = 1'b1;
                        ph_c   = PH_IDLE;
                        reproc = 1'b1;
                    end
                end
                PH_DASH:
                begin
                    if (head.cls == CL_DIGIT)
                    begin
                        second_c = acc_digit('0, head.digit);
                        ph_c     = PH_SECOND;
                    end
                    else if (head.cls != CL_BLANK)
                    begin
                        err_c = ERR_FORMAT;
                        ph_c  = PH_IDLE;
                    end
                end
                PH_SECOND:
                begin
                    if (head.cls == CL_DIGIT)
                        second_c = acc_digit(second_e, head.digit);
                    else
                    begin
                        rng_c  = 1'b1;
                        hi_c   = second_e;
                        ph_c   = PH_IDLE;
                        reproc = 1'b1;
                    end
                end
                default:
                    reproc = 1'b1;
            endcase
            cap_c = rng_c && (lo_c <= hi_c) && (hi_c >= NUM_W'(SET_BITS));
            if (reproc && !cap_c)
            begin
                if (head.cls == CL_DASH || head.cls == CL_DOT)
                    err_c = ERR_SIGN;
                else if (head.cls == CL_DIGIT)
                begin
                    first_c = acc_digit('0, head.digit);
                    ph_c    = PH_FIRST;
                end
            end
            if (cap_c)
                err_c = ERR_CAP;
        end
    end

    // end-of-list step
    always_comb
    begin
        rng_f = 1'b0;
        cap_f = 1'b0;
        err_f = err_reg;
        hi_f  = first_reg;
        if (err_reg == ERR_NONE)
        begin
            unique case (phase_reg)
                PH_FIRST:  rng_f = 1'b1;
                PH_DASH:   err_f = ERR_FORMAT;
                PH_SECOND:
                begin
                    rng_f = 1'b1;
                    hi_f  = second_reg;
                end
                default:   rng_f = 1'b0;
            endcase
            cap_f = rng_f && (first_reg <= hi_f) && (hi_f >= NUM_W'(SET_BITS));
            if (cap_f)
                err_f = ERR_CAP;
        end
    end

    // shared range setup
    always_comb
    begin
        rng_req  = (state_reg == S_FINISH) ? rng_f : rng_c;
        rng_lo   = (state_reg == S_FINISH) ? first_reg : lo_c;
        rng_hi   = (state_reg == S_FINISH) ? hi_f : hi_c;
        rng_top  = (rng_hi >= NUM_W'(SET_BITS)) ? NUM_W'(SET_BITS - 1) : rng_hi;
        rng_fill = rng_req && (rng_lo <= rng_hi) && (rng_lo <= rng_top);
    end

    assign lo_w      = WIDX_W'(fill_lo_reg >> BIT_W);
    assign top_w     = WIDX_W'(fill_top_reg >> BIT_W);
    assign fill_done = (fill_w_reg == top_w);

    always_comb
    begin
        fill_mask = '1;
        if (fill_w_reg == lo_w)
            fill_mask = fill_mask & ({WORD_BITS{1'b1}} << fill_lo_reg[BIT_W-1:0]);
        if (fill_w_reg == top_w)
            fill_mask = fill_mask & ({WORD_BITS{1'b1}} >> (~fill_top_reg[BIT_W-1:0]));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (take_char)
                begin
                    if (rng_fill)
                        state_next = S_FILL;
                    else if (head.last)
                        state_next = S_FINISH;
                end
            S_FILL:
                if (fill_done)
                begin
                    if (pend_fin_reg)
                        state_next = S_FINISH;
                    else if (pend_reply_reg)
                        state_next = S_REPLY;
                    else
                        state_next = S_IDLE;
                end
            S_FINISH:
                state_next = rng_fill ? S_FILL : S_REPLY;
            S_REPLY:
                if (slot_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        err_next        = err_reg;
        open_next       = open_reg;
        bitmap_next     = bitmap_reg;
        fill_w_next     = fill_w_reg;
        fill_lo_next    = fill_lo_reg;
        fill_top_next   = fill_top_reg;
        pend_fin_next   = pend_fin_reg;
        pend_reply_next = pend_reply_reg;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_member_next = out_member_reg;
        out_empty_next  = out_empty_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take_query)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_QUERY;
                    out_status_next = ERR_NONE;
                    out_member_next = member;
                    out_empty_next  = empty;
                end
                if (take_char)
                begin
                    if (!open_reg)
                        for (int i = 0; i < WORD_COUNT; i++)
                            bitmap_next[i] = '0;
                    open_next       = 1'b1;
                    phase_next      = ph_c;
                    first_next      = first_c;
                    second_next     = second_c;
                    err_next        = err_c;
                    fill_lo_next    = rng_lo;
                    fill_top_next   = rng_top;
                    fill_w_next     = WIDX_W'(rng_lo >> BIT_W);
                    pend_fin_next   = head.last;
                    pend_reply_next = 1'b0;
                end
            end
            S_FILL:
            begin
                bitmap_next[fill_w_reg] = bitmap_reg[fill_w_reg] | fill_mask;
                fill_w_next = fill_w_reg + 1'b1;
            end
            S_FINISH:
            begin
                err_next        = err_f;
                phase_next      = PH_IDLE;
                open_next       = 1'b0;
                fill_lo_next    = rng_lo;
                fill_top_next   = rng_top;
                fill_w_next     = WIDX_W'(rng_lo >> BIT_W);
                pend_fin_next   = 1'b0;
                pend_reply_next = 1'b1;
            end
            S_REPLY:
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_STATUS;
                    out_status_next = err_reg;
                    out_member_next = 1'b0;
                    out_empty_next  = empty;
                end
            default:
                pend_reply_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_IDLE;
            first_reg      <= '0;
            second_reg     <= '0;
            err_reg        <= ERR_NONE;
            open_reg       <= 1'b0;
            pend_fin_reg   <= 1'b0;
            pend_reply_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < WORD_COUNT; i++)
                bitmap_reg[i] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            err_reg        <= err_next;
            open_reg       <= open_next;
            pend_fin_reg   <= pend_fin_next;
            pend_reply_reg <= pend_reply_next;
            out_valid_reg  <= out_valid_next;
            bitmap_reg     <= bitmap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_w_reg     <= fill_w_next;
        fill_lo_reg    <= fill_lo_next;
        fill_top_reg   <= fill_top_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_member_reg <= out_member_next;
        out_empty_reg  <= out_empty_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_status = out_status_reg;
    assign out_member = out_member_reg;
    assign out_empty  = out_empty_reg;

`include "assert_macros.svh"
    `ASSERT_IMPLY(a_fill_word_bound, state_reg == S_FILL, fill_w_reg <= top_w)
    `ASSERT_IMPLY(a_fill_order, state_reg == S_FILL, fill_lo_reg <= fill_top_reg)
    `ASSERT_NEXT(a_reply_loaded, state_reg == S_REPLY && slot_free, out_valid_reg)

endmodule

/* rtl/core/number_range_list_to_bitmap.sv */
// Top level of the range list to bitmap block: APB register, front, queue, back.
// Depends on rlb_pkg, rlb_front, rlb_queue, rlb_back.
`timescale 1ns / 1ps
//
//  channel   direction  beat contents
//  s_axis    in         tdata {query_value, char_code}, tuser mode, tlast last_char
//  m_axis    out        tdata {is_empty, is_member, status}, tuser reply_kind
//  apb       in/out     max_value at byte address 0
//
//  A query is answered in S_IDLE once the m_axis slot is free. A list character is taken
//  in S_IDLE; a range it closes is then filled word by word in S_FILL (up to WORD_COUNT
//  words); a final character adds S_FINISH, possibly a second fill, and S_REPLY.
//  The word-serial fill of the 8 x 32 bit bitmap sets the rate.
//  Reset clears the bitmap, the parser and max_value at once.
//  A two-beat queue lets input beats land while the back end fills or waits on m_axis.

module number_range_list_to_bitmap (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] char_code, [15:8] query_value
    input  logic        s_axis_tuser,   // [0] mode
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] status, [3] is_member, [4] is_empty
    output logic        m_axis_tuser,   // [0] reply_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rlb_pkg::*;

    logic [7:0] max_value_reg, max_value_next;
    entry_t     in_entry, head;
    logic       full, push, pop, head_valid;
    logic [2:0] status;
    logic       is_member, is_empty;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_VALUE) ? {24'd0, max_value_reg} : 32'd0;

    always_comb
    begin
        max_value_next = max_value_reg;
        if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_VALUE)
            max_value_next = pwdata[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_value_reg <= '0;
        else
            max_value_reg <= max_value_next;
    end

    assign s_axis_tready = !full;
    assign push          = s_axis_tvalid && !full;

    rlb_front u_front (
        .mode        (s_axis_tuser),
        .char_code   (s_axis_tdata[7:0]),
        .last_char   (s_axis_tlast),
        .query_value (s_axis_tdata[15:8]),
        .entry       (in_entry)
    );

    rlb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (in_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    rlb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .max_value  (max_value_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (m_axis_tuser),
        .out_status (status),
        .out_member (is_member),
        .out_empty  (is_empty)
    );

    assign m_axis_tdata = {3'd0, is_empty, is_member, status};

endmodule

/* dv/tb_number_range_list_to_bitmap.sv */
// Self-checking bench for number_range_list_to_bitmap: range list text in, status/query out.
// Depends on rlb_pkg and the block's RTL; predicts replies from its own copy of the parser state.
`timescale 1ns / 1ps

module tb_number_range_list_to_bitmap;
    import rlb_pkg::*;

    typedef struct packed {
        logic       mode;
        logic [7:0] ch;
        logic       last;
        logic [7:0] qv;
    } beat_t;

    typedef struct packed {
        logic       kind;
        logic [2:0] status;
        logic       member;
        logic       empty;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    number_range_list_to_bitmap DUT (.*);

    // predictor state
    logic [SET_BITS-1:0] bitmap;
    phase_t              phase;
    int unsigned         num_a;
    int unsigned         num_b;
    status_t             err;
    logic                in_list;
    int unsigned         max_val;

    beat_t  pending[$];
    reply_t replies[$];
    int     errors;
    int     n_status;
    int     n_query;
    int     n_beats;
    bit     hold_off;
    int     burst_left;
    int     gap_left;
    int     stall_mode;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12ns * 400000);
        $display("timeout at %0t", $time);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned acc10(int unsigned n, logic [7:0] c);
        int unsigned v;
        v = n * 10 + (c - CH_ZERO);
        return (v > SET_BITS) ? SET_BITS : v;
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic fill_range(int unsigned lo, int unsigned hi);
        if (lo > hi)
            return;
        for (int unsigned v = lo; v <= hi && v < SET_BITS; v++)
            bitmap[v] = 1'b1;
        if (hi >= SET_BITS)
            err = ERR_CAP;
    endtask

    task automatic parse_char(logic [7:0] c);
        if (err != ERR_NONE)
            return;
        if (phase == PH_FIRST)
        begin
            if (is_dig(c))
            begin
                num_a = acc10(num_a, c);
                return;
            end
            if (c == CH_DASH)
            begin
                num_b = 0;
                phase = PH_DASH;
                return;
            end
            if (c == CH_PLUS)
            begin
                phase = PH_IDLE;
                if (max_val == 0)
                    err = ERR_NOMAX;
                else
                    fill_range(num_a, max_val);
                return;
            end
            fill_range(num_a, num_a);
            phase = PH_IDLE;
        end
        else if (phase == PH_DASH)
        begin
            if (is_dig(c))
            begin
                num_b = acc10(0, c);
                phase = PH_SECOND;
            end
            else if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR))
            begin
                err = ERR_FORMAT;
                phase = PH_IDLE;
            end
            return;
        end
        else if (phase == PH_SECOND)
        begin
            if (is_dig(c))
            begin
                num_b = acc10(num_b, c);
                return;
            end
            fill_range(num_a, num_b);
            phase = PH_IDLE;
        end
        if (err != ERR_NONE)
            return;
        if (c == CH_DASH || c == CH_DOT)
            err = ERR_SIGN;
        else if (is_dig(c))
        begin
            num_a = acc10(0, c);
            phase = PH_FIRST;
        end
    endtask

    task automatic predict_beat(beat_t b);
        reply_t r;
        if (b.mode != MODE_CHAR)
        begin
            r = '{KIND_QUERY, ERR_NONE, bitmap[b.qv], bitmap == '0};
            replies.push_back(r);
            return;
        end
        if (!in_list)
        begin
            bitmap = '0;
            phase = PH_IDLE;
            num_a = 0;
            num_b = 0;
            err = ERR_NONE;
            in_list = 1'b1;
        end
        parse_char(b.ch);
        if (!b.last)
            return;
        if (err == ERR_NONE)
        begin
            if (phase == PH_FIRST)
                fill_range(num_a, num_a);
            else if (phase == PH_DASH)
                err = ERR_FORMAT;
            else if (phase == PH_SECOND)
                fill_range(num_a, num_b);
        end
        phase = PH_IDLE;
        in_list = 1'b0;
        r = '{KIND_STATUS, err, 1'b0, bitmap == '0};
        replies.push_back(r);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            s_axis_tlast  <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_beat(pending.pop_front());
                n_beats++;
            end
            if ((!s_axis_tvalid || s_axis_tready))
            begin
                if (pending.size() == 0 || hold_off || gap_left > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {pending[0].qv, pending[0].ch};
                    s_axis_tuser  <= pending[0].mode;
                    s_axis_tlast  <= pending[0].last;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        reply_t got;
        reply_t exp;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[3], m_axis_tdata[4]};
                if (replies.size() == 0)
                begin
                    $display("%0t: unexpected reply %h", $time, got);
                    errors++;
                end
                else
                begin
                    exp = replies.pop_front();
                    if (got.kind == KIND_QUERY)
                        n_query++;
                    else
                        n_status++;
                    if (got.kind !== exp.kind || got.status !== exp.status
                        || got.member !== exp.member || got.empty !== exp.empty)
                    begin
                        $display("%0t: mismatch exp kind %0d st %0d mem %0d emp %0d",
                                 $time, exp.kind, exp.status, exp.member, exp.empty);
                        $display("%0t:          got kind %0d st %0d mem %0d emp %0d",
                                 $time, got.kind, got.status, got.member, got.empty);
                        errors++;
                    end
                end
                if (m_axis_tdata[7:5] !== 3'b0)
                begin
                    $display("%0t: pad bits exp 0 got %b", $time, m_axis_tdata[7:5]);
                    errors++;
                end
            end
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
        if ($urandom_range(0, 99) == 0)
            stall_mode <= $urandom_range(0, 2);

    task automatic push_char(logic [7:0] c, logic last);
        beat_t b;
        b = '{MODE_CHAR, c, last, 8'($urandom)};
        pending.push_back(b);
    endtask

    task automatic push_query(logic [7:0] q);
        beat_t b;
        b = '{1'b1, 8'($urandom), 1'($urandom), q};
        pending.push_back(b);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endtask

    task automatic drain();
        wait (pending.size() == 0);
        @(posedge clk);
        wait (replies.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic reg_write(int unsigned v);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_VALUE, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        max_val = v & 8'hff;
    endtask

    function automatic string rand_number();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return $sformatf("%0d", $urandom_range(256, 9999));
        if (k < 3)
            return $sformatf("%0d", $urandom_range(200, 255));
        return $sformatf("%0d", $urandom_range(0, 255));
    endfunction

    function automatic string rand_sep();
        string seps[6] = '{",", ", ", " ", ",\t", "\n", ";"};
        return seps[$urandom_range(0, 5)];
    endfunction

    function automatic string rand_list();
        string s;
        int n;
        n = $urandom_range(1, 4);
        s = "";
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 5))
                0, 1: s = {s, rand_number()};
                2, 3: s = {s, rand_number(), ($urandom_range(0, 3) == 0) ? "- " : "-",
                           rand_number()};
                4: s = {s, rand_number(), "+"};
                default: s = {s, " "};
            endcase
            if (i != n - 1)
                s = {s, rand_sep()};
        end
        if ($urandom_range(0, 7) == 0)
        begin
            int p;
            string bad[5] = '{"-", ".", "+", "x", "-,"};
            p = $urandom_range(0, s.len());
            s = {s.substr(0, p - 1), bad[$urandom_range(0, 4)], s.substr(p, s.len() - 1)};
        end
        return s;
    endfunction

    initial
    begin
        int unsigned maxes[4] = '{0, 255, 1, 100};
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        errors = 0; n_status = 0; n_query = 0; n_beats = 0;
        hold_off = 1'b0; stall_mode = 0;
        bitmap = '0; phase = PH_IDLE; num_a = 0; num_b = 0; err = ERR_NONE;
        in_list = 1'b0; max_val = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed, max_value still 0
        push_query(8'd0);
        push_text("5");
        push_text("10+");
        push_text("0, 255");
        push_query(8'd255);
        push_query(8'd1);
        push_text("-3");
        push_text("1.5");
        push_text("4-");
        push_text("2-x");
        push_text("250-300");
        drain();
        reg_write(255);
        push_text("9-3,200+");
        push_query(8'd200);
        push_char(8'd255, 1'b0);
        push_char(8'd0, 1'b1);
        push_text("1- 7");
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            reg_write(ph == 3 ? $urandom_range(1, 254) : maxes[ph]);
            while (n_beats < 490 * (ph + 1))
            begin
                case ($urandom_range(0, 9))
                    0: push_query(8'($urandom));
                    1: push_char(8'($urandom), 1'($urandom_range(0, 5) == 0));
                    default: push_text(rand_list());
                endcase
                if (pending.size() > 20)
                    wait (pending.size() < 8);
                if (ph == 1 && n_beats > 700 && !hold_off && n_beats < 720)
                begin
                    hold_off = 1'b1;
                    wait (replies.size() == 0);
                    hold_off = 1'b0;
                end
            end
            push_char(",", 1'b1);
            drain();
        end

        $display("covered %0d beats: %0d status replies, %0d query replies, four max_value settings",
                 n_beats, n_status, n_query);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
